// File: hw/rtl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared constants and types of the RGB to HSV converter pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

   // hue is kept in 1/64 degree
   localparam int HUE_W     = 15;
   // quotient of the hue division never exceeds one sixth of a turn (3840)
   localparam int HUE_QUO_W = 12;

   localparam logic [HUE_W-1:0] HUE_SIXTH     = 15'd3840;
   localparam logic [HUE_W-1:0] HUE_GREEN_OFS = 15'd7680;
   localparam logic [HUE_W-1:0] HUE_BLUE_OFS  = 15'd15360;
   localparam logic [HUE_W-1:0] HUE_TURN      = 15'd23040;

   // channel that holds the maximum
   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

endpackage

`default_nettype wire

// File: hw/rtl/rgb_to_hsv_converter_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit
// Fixed-point RGB to HSV conversion of a pixel stream, one pixel per clock while rsp_tready is high.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one pixel per transaction: red, green, blue in req_tdata.
//  - rsp_* returns one transaction per pixel, in order: hue (1/64 degree,
//    0..23039), saturation floor(FULL*delta/max) and value (max channel).
//  - The pipe is made of two front stages (extremes, numerators), QUO_W
//    divider stages that retire one quotient bit each for hue and
//    saturation, and one output stage, where QUO_W = max(12, CHANNEL_BITS).
//  - Throughput is one pixel per cycle while rsp_tready is high; every stage has
//    its own valid bit and ready is chained stage by stage, so bubbles collapse.
//  - When rsp_tready is low the output register holds its transaction and
//    earlier stages keep filling until the pipe is full; then req_tready
//    drops. Nothing is lost or repeated.
//  - Synchronous reset empties the pipe; no other state exists.
//  - Grey pixels (max == min) give hue 0 and saturation 0.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter_unit #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                                     clock,
   input  logic                                                     reset,
   // req_tdata: red, green, blue (low to high), zero padded to bytes
   input  logic                                                     req_tvalid,
   output logic                                                     req_tready,
   input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]                      req_tdata,
   // rsp_tdata: hue[14:0], saturation, value (low to high), zero padded
   output logic                                                     rsp_tvalid,
   input  logic                                                     rsp_tready,
   output logic [((rhc_pkg::HUE_W+2*CHANNEL_BITS+7)/8)*8-1:0]       rsp_tdata
);
   import rhc_pkg::*;

   localparam int CB    = CHANNEL_BITS;
   localparam int QUO_W = (CB > HUE_QUO_W) ? CB : HUE_QUO_W;
   localparam int OUT_W = ((HUE_W + 2*CB + 7) / 8) * 8;

   // input field split
   logic [CB-1:0] red, green, blue;

   // front -> divider
   logic                f_valid, f_ready;
   logic [QUO_W+CB-1:0] f_hue_num, f_sat_num;
   logic [CB-1:0]       f_delta, f_value;
   logic                f_neg, f_gray;
   sector_type          f_sector;

   // divider -> back
   logic                d_valid, d_ready;
   logic [QUO_W-1:0]    d_hue_quo, d_sat_quo;
   logic                d_hue_rem_nz;
   logic [CB-1:0]       d_value;
   logic                d_neg, d_gray;
   sector_type          d_sector;

   // result fields
   logic [HUE_W-1:0]    rsp_hue;
   logic [CB-1:0]       rsp_saturation, rsp_value;

   assign red   = req_tdata[CB-1:0];
   assign green = req_tdata[2*CB-1:CB];
   assign blue  = req_tdata[3*CB-1:2*CB];

   rhc_front #(.CB(CB), .QB(QUO_W)) u_front (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .red      (red),
      .green    (green),
      .blue     (blue),
      .dn_valid (f_valid),
      .dn_ready (f_ready),
      .hue_num  (f_hue_num),
      .sat_num  (f_sat_num),
      .delta    (f_delta),
      .value    (f_value),
      .neg      (f_neg),
      .gray     (f_gray),
      .sector   (f_sector)
   );

   rhc_divider #(.CB(CB), .QB(QUO_W)) u_divider (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (f_valid),
      .up_ready   (f_ready),
      .hue_num    (f_hue_num),
      .sat_num    (f_sat_num),
      .delta      (f_delta),
      .value      (f_value),
      .neg        (f_neg),
      .gray       (f_gray),
      .sector     (f_sector),
      .dn_valid   (d_valid),
      .dn_ready   (d_ready),
      .hue_quo    (d_hue_quo),
      .hue_rem_nz (d_hue_rem_nz),
      .sat_quo    (d_sat_quo),
      .value_out  (d_value),
      .neg_out    (d_neg),
      .gray_out   (d_gray),
      .sector_out (d_sector)
   );

   rhc_back #(.CB(CB), .QB(QUO_W)) u_back (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (d_valid),
      .up_ready   (d_ready),
      .hue_quo    (d_hue_quo),
      .hue_rem_nz (d_hue_rem_nz),
      .sat_quo    (d_sat_quo),
      .value      (d_value),
      .neg        (d_neg),
      .gray       (d_gray),
      .sector     (d_sector),
      .dn_valid   (rsp_tvalid),
      .dn_ready   (rsp_tready),
      .hue        (rsp_hue),
      .saturation (rsp_saturation),
      .value_out  (rsp_value)
   );

   assign rsp_tdata = OUT_W'({rsp_value, rsp_saturation, rsp_hue});

   // hue always stays below a full turn
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_hue < HUE_TURN))
      else $error("hue out of range");

   // zero saturation only for grey pixels, which carry zero hue
   a_grey_hue: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_saturation == '0) |-> (rsp_hue == '0))
      else $error("grey pixel with nonzero hue");

   // black pixels carry zero saturation
   a_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_value == '0) |-> (rsp_saturation == '0))
      else $error("black pixel with nonzero saturation");

   // pipe comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

// File: hw/rtl/rhc_front.sv
// ----------------------------------------------------------------------------
// rhc_front
// Two stages: max/min/sector pick, then numerators of both divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_front #(
   parameter int CB = 8,
   parameter int QB = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  logic [CB-1:0]        red,
   input  logic [CB-1:0]        green,
   input  logic [CB-1:0]        blue,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output logic [QB+CB-1:0]     hue_num,
   output logic [QB+CB-1:0]     sat_num,
   output logic [CB-1:0]        delta,
   output logic [CB-1:0]        value,
   output logic                 neg,
   output logic                 gray,
   output rhc_pkg::sector_type  sector
);
   import rhc_pkg::*;

   localparam int NUM_W = QB + CB;
   localparam logic [CB-1:0] FULL = {CB{1'b1}};

   // stage A: extremes and signed difference
   logic                 a_valid_ff;
   sector_type           a_sector_ff, a_sector_in;
   logic signed [CB:0]   a_diff_ff, a_diff_in;
   logic [CB-1:0]        a_delta_ff, a_delta_in;
   logic [CB-1:0]        a_max_ff, a_max_in;
   logic [CB-1:0]        min_c;
   logic                 en_a;

   // stage B: division numerators
   logic                 b_valid_ff;
   logic [NUM_W-1:0]     b_hue_num_ff, b_hue_num_in;
   logic [NUM_W-1:0]     b_sat_num_ff, b_sat_num_in;
   logic [CB-1:0]        b_delta_ff, b_max_ff;
   logic                 b_neg_ff, b_neg_in;
   logic                 b_gray_ff, b_gray_in;
   sector_type           b_sector_ff;
   logic [CB:0]          abs_diff;
   logic                 en_b;

   assign en_b     = !b_valid_ff | dn_ready;
   assign en_a     = !a_valid_ff | en_b;
   assign up_ready = en_a;

   always_comb begin
      a_max_in = red;
      if (green > a_max_in) a_max_in = green;
      if (blue > a_max_in)  a_max_in = blue;
      min_c = red;
      if (green < min_c) min_c = green;
      if (blue < min_c)  min_c = blue;
      a_delta_in = a_max_in - min_c;
      // ties go to red, then green
      if (a_max_in == red) begin
         a_sector_in = SECTOR_RED;
         a_diff_in   = $signed({1'b0, green}) - $signed({1'b0, blue});
      end else if (a_max_in == green) begin
         a_sector_in = SECTOR_GREEN;
         a_diff_in   = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         a_sector_in = SECTOR_BLUE;
         a_diff_in   = $signed({1'b0, red}) - $signed({1'b0, green});
      end
   end

   always_comb begin
      b_neg_in     = a_diff_ff[CB];
      abs_diff     = b_neg_in ? $unsigned(-a_diff_ff) : $unsigned(a_diff_ff);
      b_hue_num_in = NUM_W'(abs_diff) * NUM_W'(HUE_SIXTH);
      b_sat_num_in = NUM_W'(a_delta_ff) * NUM_W'(FULL);
      b_gray_in    = (a_delta_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (en_a) a_valid_ff <= up_valid;
         if (en_b) b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_sector_ff <= a_sector_in;
         a_diff_ff   <= a_diff_in;
         a_delta_ff  <= a_delta_in;
         a_max_ff    <= a_max_in;
      end
      if (en_b) begin
         b_hue_num_ff <= b_hue_num_in;
         b_sat_num_ff <= b_sat_num_in;
         b_delta_ff   <= a_delta_ff;
         b_max_ff     <= a_max_ff;
         b_neg_ff     <= b_neg_in;
         b_gray_ff    <= b_gray_in;
         b_sector_ff  <= a_sector_ff;
      end
   end

   assign dn_valid = b_valid_ff;
   assign hue_num  = b_hue_num_ff;
   assign sat_num  = b_sat_num_ff;
   assign delta    = b_delta_ff;
   assign value    = b_max_ff;
   assign neg      = b_neg_ff;
   assign gray     = b_gray_ff;
   assign sector   = b_sector_ff;

endmodule

`default_nettype wire

// File: hw/rtl/rhc_divider.sv
// ----------------------------------------------------------------------------
// rhc_divider
// Pipelined restoring divider, one quotient bit per stage, two lanes
// (hue and saturation) stepping in lockstep.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_divider #(
   parameter int CB = 8,
   parameter int QB = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  logic [QB+CB-1:0]     hue_num,
   input  logic [QB+CB-1:0]     sat_num,
   input  logic [CB-1:0]        delta,
   input  logic [CB-1:0]        value,
   input  logic                 neg,
   input  logic                 gray,
   input  rhc_pkg::sector_type  sector,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output logic [QB-1:0]        hue_quo,
   output logic                 hue_rem_nz,
   output logic [QB-1:0]        sat_quo,
   output logic [CB-1:0]        value_out,
   output logic                 neg_out,
   output logic                 gray_out,
   output rhc_pkg::sector_type  sector_out
);
   import rhc_pkg::*;

   // one restoring step: returns {quotient bit, new remainder}
   function automatic logic [CB:0] div_step(input logic [CB-1:0] rem,
                                            input logic          nbit,
                                            input logic [CB-1:0] den);
      logic [CB:0] t;
      logic [CB:0] d;
      logic [CB:0] s;
      t = {rem, nbit};
      d = {1'b0, den};
      s = t - d;
      if (t >= d) begin
         return {1'b1, s[CB-1:0]};
      end
      return {1'b0, t[CB-1:0]};
   endfunction

   logic [QB:1]   v_ff;
   logic [QB:1]   en;
   logic [CB-1:0] rh_ff [1:QB];
   logic [CB-1:0] rs_ff [1:QB];
   logic [QB-1:0] qh_ff [1:QB];
   logic [QB-1:0] qs_ff [1:QB];
   logic [CB-1:0] dh_ff [1:QB];
   logic [CB-1:0] ds_ff [1:QB];
   logic          neg_ff  [1:QB];
   logic          gray_ff [1:QB];
   sector_type    sec_ff  [1:QB];

   assign up_ready = en[1];

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic          v_src;
      logic [CB-1:0] rh_src, rs_src, dh_src, ds_src;
      logic [QB-1:0] qh_src, qs_src;
      logic          neg_src, gray_src;
      sector_type    sec_src;
      logic [CB:0]   step_h, step_s;

      if (k == 0) begin : g_first
         assign v_src    = up_valid;
         assign rh_src   = hue_num[QB+CB-1:QB];
         assign qh_src   = hue_num[QB-1:0];
         assign rs_src   = sat_num[QB+CB-1:QB];
         assign qs_src   = sat_num[QB-1:0];
         assign dh_src   = delta;
         assign ds_src   = value;
         assign neg_src  = neg;
         assign gray_src = gray;
         assign sec_src  = sector;
      end else begin : g_next
         assign v_src    = v_ff[k];
         assign rh_src   = rh_ff[k];
         assign qh_src   = qh_ff[k];
         assign rs_src   = rs_ff[k];
         assign qs_src   = qs_ff[k];
         assign dh_src   = dh_ff[k];
         assign ds_src   = ds_ff[k];
         assign neg_src  = neg_ff[k];
         assign gray_src = gray_ff[k];
         assign sec_src  = sec_ff[k];
      end

      if (k == QB - 1) begin : g_last_en
         assign en[k+1] = !v_ff[k+1] | dn_ready;
      end else begin : g_mid_en
         assign en[k+1] = !v_ff[k+1] | en[k+2];
      end

      assign step_h = div_step(rh_src, qh_src[QB-1], dh_src);
      assign step_s = div_step(rs_src, qs_src[QB-1], ds_src);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en[k+1]) begin
            v_ff[k+1] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en[k+1]) begin
            rh_ff[k+1]   <= step_h[CB-1:0];
            qh_ff[k+1]   <= {qh_src[QB-2:0], step_h[CB]};
            rs_ff[k+1]   <= step_s[CB-1:0];
            qs_ff[k+1]   <= {qs_src[QB-2:0], step_s[CB]};
            dh_ff[k+1]   <= dh_src;
            ds_ff[k+1]   <= ds_src;
            neg_ff[k+1]  <= neg_src;
            gray_ff[k+1] <= gray_src;
            sec_ff[k+1]  <= sec_src;
         end
      end
   end

   assign dn_valid   = v_ff[QB];
   assign hue_quo    = qh_ff[QB];
   assign hue_rem_nz = (rh_ff[QB] != '0);
   assign sat_quo    = qs_ff[QB];
   assign value_out  = ds_ff[QB];
   assign neg_out    = neg_ff[QB];
   assign gray_out   = gray_ff[QB];
   assign sector_out = sec_ff[QB];

endmodule

`default_nettype wire

// File: hw/rtl/rhc_back.sv
// ----------------------------------------------------------------------------
// rhc_back
// Sector offset and floor correction of hue, grey masking, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_back #(
   parameter int CB = 8,
   parameter int QB = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       up_valid,
   output logic                       up_ready,
   input  logic [QB-1:0]              hue_quo,
   input  logic                       hue_rem_nz,
   input  logic [QB-1:0]              sat_quo,
   input  logic [CB-1:0]              value,
   input  logic                       neg,
   input  logic                       gray,
   input  rhc_pkg::sector_type        sector,
   output logic                       dn_valid,
   input  logic                       dn_ready,
   output logic [rhc_pkg::HUE_W-1:0]  hue,
   output logic [CB-1:0]              saturation,
   output logic [CB-1:0]              value_out
);
   import rhc_pkg::*;

   logic               o_valid_ff;
   logic [HUE_W-1:0]   hue_ff, hue_in;
   logic [CB-1:0]      sat_ff, sat_in;
   logic [CB-1:0]      value_ff;
   logic [HUE_W:0]     base, quo, rnd, hue_sum;
   logic               en;

   assign en       = !o_valid_ff | dn_ready;
   assign up_ready = en;

   always_comb begin
      case (sector)
         SECTOR_RED:   base = neg ? {1'b0, HUE_TURN} : '0;
         SECTOR_GREEN: base = {1'b0, HUE_GREEN_OFS};
         SECTOR_BLUE:  base = {1'b0, HUE_BLUE_OFS};
         default:      base = '0;
      endcase
      quo = (HUE_W+1)'(hue_quo[HUE_QUO_W-1:0]);
      rnd = (HUE_W+1)'(hue_rem_nz);
      // negative difference: floor is minus the ceiling of the magnitude
      hue_sum = neg ? (base - quo - rnd) : (base + quo);
      hue_in  = gray ? '0 : hue_sum[HUE_W-1:0];
      sat_in  = gray ? '0 : sat_quo[CB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (en) begin
         o_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         value_ff <= value;
      end
   end

   assign dn_valid   = o_valid_ff;
   assign hue        = hue_ff;
   assign saturation = sat_ff;
   assign value_out  = value_ff;

endmodule

`default_nettype wire

// File: sim/hsv_pixel_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_pixel_checker
// Watches both stream channels of the RGB to HSV converter and checks every
// response against a fixed-point conversion of the pixel that was accepted.
// ----------------------------------------------------------------------------

module hsv_pixel_checker #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               req_tvalid,
   input  logic                                               req_tready,
   // red, green, blue (low to high)
   input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]                req_tdata,
   input  logic                                               rsp_tvalid,
   input  logic                                               rsp_tready,
   // hue, saturation, value (low to high)
   input  logic [((rhc_pkg::HUE_W+2*CHANNEL_BITS+7)/8)*8-1:0] rsp_tdata,
   output int                                                 error_total,
   output int                                                 pixels_in_flight
);

   import rhc_pkg::*;

   localparam int FULL = (1 << CHANNEL_BITS) - 1;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] value;
      logic [CHANNEL_BITS-1:0] saturation;
      logic [HUE_W-1:0]        hue;
   } hsv_type;

   hsv_type pending_hsv[$];
   int      error_count = 0;

   initial begin
      error_total      = 0;
      pixels_in_flight = 0;
   end

   function automatic hsv_type convert_pixel(input logic [CHANNEL_BITS-1:0] r, g, b);
      int         red, green, blue, peak, trough, spread, numer, offset, hue;
      sector_type sector;
      hsv_type    res;
      red    = r;
      green  = g;
      blue   = b;
      peak   = red;
      trough = red;
      sector = SECTOR_RED;
      if (green > peak) begin
         peak   = green;
         sector = SECTOR_GREEN;
      end
      if (blue > peak) begin
         peak   = blue;
         sector = SECTOR_BLUE;
      end
      if (green < trough) trough = green;
      if (blue < trough) trough = blue;
      spread = peak - trough;
      res.value      = peak[CHANNEL_BITS-1:0];
      res.hue        = '0;
      res.saturation = '0;
      if (spread > 0) begin
         case (sector)
            SECTOR_RED: begin
               numer  = int'(HUE_SIXTH) * (green - blue);
               offset = 0;
            end
            SECTOR_GREEN: begin
               numer  = int'(HUE_SIXTH) * (blue - red);
               offset = int'(HUE_GREEN_OFS);
            end
            default: begin
               numer  = int'(HUE_SIXTH) * (red - green);
               offset = int'(HUE_BLUE_OFS);
            end
         endcase
         // floor toward minus infinity, SV division truncates
         hue = numer / spread;
         if (numer < 0 && hue * spread != numer) hue = hue - 1;
         hue = hue + offset;
         if (hue < 0) hue = hue + int'(HUE_TURN);
         res.hue        = hue[HUE_W-1:0];
         res.saturation = CHANNEL_BITS'((FULL * spread) / peak);
      end
      return res;
   endfunction

   always @(posedge clock) begin
      hsv_type want, got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            pending_hsv.push_back(convert_pixel(req_tdata[CHANNEL_BITS-1:0],
                                                req_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS],
                                                req_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[HUE_W+2*CHANNEL_BITS-1:0];
            if (pending_hsv.size() == 0) begin
               $error("response transaction with no pixel outstanding: 0x%0h", rsp_tdata);
               error_count++;
            end else begin
               want = pending_hsv.pop_front();
               if (got.hue !== want.hue) begin
                  $error("hue mismatch: expected %0d, actual %0d", want.hue, got.hue);
                  error_count++;
               end
               if (got.saturation !== want.saturation) begin
                  $error("saturation mismatch: expected %0d, actual %0d",
                         want.saturation, got.saturation);
                  error_count++;
               end
               if (got.value !== want.value) begin
                  $error("value mismatch: expected %0d, actual %0d", want.value, got.value);
                  error_count++;
               end
            end
         end
      end
      error_total      <= error_count;
      pixels_in_flight <= pending_hsv.size();
   end

endmodule

// File: sim/rgb_to_hsv_converter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit_tb
// Streams directed and random RGB pixels through the converter with random
// gaps on both sides and one long output stall; a checker beside the unit
// predicts each HSV response and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------

module rgb_to_hsv_converter_unit_tb;

   localparam int CB        = 8;
   localparam int REQ_W     = ((3*CB+7)/8)*8;
   localparam int RSP_W     = ((rhc_pkg::HUE_W+2*CB+7)/8)*8;
   // idle-cycle watchdog; worst legit gap is the long hold-off plus latency
   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_OFF   = 80;
   localparam int RANDOM_PIXELS = 1450;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;

   int  error_total;
   int  pixels_in_flight;
   int  pixels_sent = 0;
   bit  held_off    = 1'b0;
   int  quiet_cycles = 0;

   // no random idling on either side within this window of pixels
   wire calm = (pixels_sent >= 700) && (pixels_sent < 1000);

   rgb_to_hsv_converter_unit #(
      .CHANNEL_BITS(CB)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   hsv_pixel_checker #(
      .CHANNEL_BITS(CB)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .error_total      (error_total),
      .pixels_in_flight (pixels_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer one pixel and hold it until the unit takes it. A one-cycle gap
   // may come first; valid is only lowered when a gap is inserted, so back
   // to back transactions keep it high without a same-step toggle.
   task automatic send_pixel(input logic [CB-1:0] r, g, b);
      if (!calm && $urandom_range(99) < 11) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({b, g, r});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
   endtask

   // Stimulus: directed corners, then random pixels of mixed shapes.
   initial begin
      int kind, base;
      logic [CB-1:0] r, g, b;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // grey levels, black and white included
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      // primaries, one per sector
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      // ties for the maximum: red beats green and blue, green beats blue
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd0,   8'd255, 8'd255);
      // red sector: blue above green (negative hue that wraps), then green above blue
      send_pixel(8'd255, 8'd0,   8'd1);
      send_pixel(8'd255, 8'd10,  8'd200);
      send_pixel(8'd200, 8'd199, 8'd0);
      // green and blue sectors, both signs of the difference
      send_pixel(8'd10,  8'd255, 8'd200);
      send_pixel(8'd200, 8'd255, 8'd10);
      send_pixel(8'd200, 8'd10,  8'd255);
      send_pixel(8'd10,  8'd200, 8'd255);
      // smallest deltas and smallest maxima
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd0,   8'd1,   8'd0);
      send_pixel(8'd0,   8'd0,   8'd1);
      send_pixel(8'd254, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd254, 8'd255);
      send_pixel(8'd1,   8'd1,   8'd0);

      for (int n = 0; n < RANDOM_PIXELS; n++) begin
         kind = $urandom_range(9);
         r = CB'($urandom);
         g = CB'($urandom);
         b = CB'($urandom);
         case (kind)
            6: begin
               // near grey: small deltas stress the division
               base = $urandom_range(255);
               r = CB'(base);
               g = CB'(base) ^ CB'($urandom_range(3));
               b = CB'(base) ^ CB'($urandom_range(3));
            end
            7: begin
               // tie for two channels
               case ($urandom_range(2))
                  0: g = r;
                  1: b = r;
                  default: b = g;
               endcase
            end
            8: begin
               // channels at the rails
               if ($urandom_range(1)) r = $urandom_range(1) ? 8'd255 : 8'd0;
               if ($urandom_range(1)) g = $urandom_range(1) ? 8'd255 : 8'd0;
               if ($urandom_range(1)) b = $urandom_range(1) ? 8'd255 : 8'd0;
            end
            9: begin
               g = r;
               b = r;
            end
            default: ;
         endcase
         send_pixel(r, g, b);
      end
      req_tvalid <= 1'b0;

      // drain once the last transaction is counted, then leave room for any
      // stray response
      @(posedge clock);
      while (pixels_in_flight != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (error_total == 0)
         $display("PASS rgb_to_hsv_converter_unit");
      else
         $display("FAIL rgb_to_hsv_converter_unit");
      $finish;
   end

   // Response side: random back-pressure, plus one long hold-off while the
   // sender keeps offering so the pipe fills and req_tready must drop.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!held_off && pixels_sent >= 300) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 11);
         end
      end
   end

   // Watchdog: a long run of cycles with no transaction on either channel
   // means the unit has hung.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("FAIL rgb_to_hsv_converter_unit");
         $finish;
      end
   end

endmodule

// File: filelist.f
hw/rtl/rhc_pkg.sv
hw/rtl/rhc_front.sv
hw/rtl/rhc_divider.sv
hw/rtl/rhc_back.sv
hw/rtl/rgb_to_hsv_converter_unit.sv
sim/hsv_pixel_checker.sv
sim/rgb_to_hsv_converter_unit_tb.sv
